FILE: src/depth_background_histogram_model_top_macros.svh
// Assertion helpers shared by the histogram model RTL.
// Each expects clk and rst_n in scope.
`ifndef DEPTH_BACKGROUND_HISTOGRAM_MODEL_TOP_MACROS_SVH
`define DEPTH_BACKGROUND_HISTOGRAM_MODEL_TOP_MACROS_SVH

// Property checked on every edge outside reset.
`define DBH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define DBH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

FILE: src/dbh_pkg.sv
`timescale 1ns / 1ps

package dbh_pkg;

  localparam int PIXELS    = 4096;
  localparam int HIST_BINS = 32;
  localparam int PIX_W     = $clog2(PIXELS);
  localparam int BIN_W     = $clog2(HIST_BINS);
  localparam int CNT_W     = 8;
  localparam int ROW_W     = HIST_BINS * CNT_W;
  localparam int DEPTH_W   = 16;
  localparam int CEIL_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  typedef enum logic [1:0] {
    MODE_INIT     = 2'd0,
    MODE_ACCUM    = 2'd1,
    MODE_FINAL    = 2'd2,
    MODE_CLASSIFY = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MID_BIN          = 3'd0,
    CFG_COUNT_THRESHOLD  = 3'd1,
    CFG_TOUCH_THICKNESS  = 3'd2,
    CFG_FINGER_THICKNESS = 3'd3,
    CFG_HAND_THICKNESS   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EXEC = 2'd2
  } state_t;

  typedef struct packed {
    logic [4:0] mid_bin;
    logic [7:0] count_threshold;
    logic [7:0] touch_thickness;
    logic [7:0] finger_thickness;
    logic [9:0] hand_thickness;
  } cfg_t;

  typedef struct packed {
    logic capture;    // input transfer: latch fields, read pixel memories
    logic scan_step;  // examine one histogram bin
    logic commit;     // write back and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_finalize;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/dbh_cfg.sv
`timescale 1ns / 1ps

module dbh_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbh_pkg::CFG_DAT_W-1:0] cfg_data,
  output dbh_pkg::cfg_t                  cfg
);
  import dbh_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MID_BIN:          cfg_nxt.mid_bin          = cfg_data[4:0];
        CFG_COUNT_THRESHOLD:  cfg_nxt.count_threshold  = cfg_data[7:0];
        CFG_TOUCH_THICKNESS:  cfg_nxt.touch_thickness  = cfg_data[7:0];
        CFG_FINGER_THICKNESS: cfg_nxt.finger_thickness = cfg_data[7:0];
        CFG_HAND_THICKNESS:   cfg_nxt.hand_thickness   = cfg_data[9:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid_bin          <= 5'd16;
      cfg_r.count_threshold  <= 8'd10;
      cfg_r.touch_thickness  <= 8'd5;
      cfg_r.finger_thickness <= 8'd15;
      cfg_r.hand_thickness   <= 10'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/dbh_ctrl.sv
`timescale 1ns / 1ps
`include "depth_background_histogram_model_top_macros.svh"

module dbh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dbh_pkg::dp_status_t st,
  output logic                in_stall,
  output dbh_pkg::ctrl_cmd_t  cmd
);
  import dbh_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = st.in_finalize ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold here while the previous result is still unclaimed
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `DBH_ASSERT_NEXT(a_direct_exec, (state_r == ST_IDLE && in_valid && !st.in_finalize), (state_r == ST_EXEC), "non-finalize item did not go straight to update")
  `DBH_ASSERT_NEXT(a_scan_exit, (state_r == ST_SCAN && st.scan_done), (state_r == ST_EXEC), "finished scan did not reach update")
  `DBH_ASSERT_NEXT(a_commit_idle, cmd.commit, (state_r == ST_IDLE && !in_stall), "no return to idle after commit")

endmodule

FILE: src/dbh_dp.sv
`timescale 1ns / 1ps
`include "depth_background_histogram_model_top_macros.svh"

module dbh_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dbh_pkg::ctrl_cmd_t                  cmd,
  input  dbh_pkg::cfg_t                       cfg,
  input  logic [1:0]                          in_mode,
  input  logic [dbh_pkg::PIX_W-1:0]           in_pixel_index,
  input  logic [dbh_pkg::DEPTH_W-1:0]         in_depth_sample,
  input  logic                                out_stall,
  output dbh_pkg::dp_status_t                 st,
  output logic                                out_valid,
  output logic signed [dbh_pkg::CEIL_W-1:0]   out_ceiling_depth,
  output logic                                out_hand_bit,
  output logic                                out_touch_bit
);
  import dbh_pkg::*;

  localparam logic [BIN_W-1:0]         BIN_LAST  = BIN_W'(HIST_BINS - 1);
  localparam logic signed [CEIL_W-1:0] BIN_MAX_S = CEIL_W'(HIST_BINS - 1);
  localparam logic [CNT_W-1:0]         CNT_SAT   = '1;

  // Bin that init and reference adoption mark.
  function automatic logic [BIN_W-1:0] mid_slot(input logic [4:0] mid);
    logic [BIN_W-1:0] slot;
    if (32'(mid) > HIST_BINS - 1) begin
      slot = BIN_LAST;
    end else begin
      slot = BIN_W'(mid);
    end
    return slot;
  endfunction

  // Per-pixel memories, one row of all bins per pixel.
  logic [DEPTH_W-1:0]        ref_mem_r  [PIXELS];
  logic [ROW_W-1:0]          row_mem_r  [PIXELS];
  logic signed [CEIL_W-1:0]  ceil_mem_r [PIXELS];

  mode_t                     mode_r;
  logic [PIX_W-1:0]          pix_r;
  logic [DEPTH_W-1:0]        sample_r;
  logic [DEPTH_W-1:0]        ref_rd_r;
  logic [ROW_W-1:0]          row_rd_r;
  logic signed [CEIL_W-1:0]  ceil_rd_r;

  logic [BIN_W-1:0]          scan_d_r;
  logic [BIN_W-1:0]          sel_d_r;
  logic [CNT_W-1:0]          best_r;
  logic                      have_r;

  logic                      out_valid_r;
  logic signed [CEIL_W-1:0]  out_ceil_r;
  logic                      out_hand_r;
  logic                      out_touch_r;

  logic [CNT_W-1:0]          scan_cnt;
  logic                      scan_hit;

  logic                      sample_nz;
  logic                      ref_zero;
  logic signed [CEIL_W-1:0]  bin_diff;
  logic [BIN_W-1:0]          bin_sel;
  logic [CNT_W-1:0]          bin_cnt;
  logic [CNT_W-1:0]          bin_inc;
  logic signed [CEIL_W-1:0]  ceil_calc;
  logic signed [CEIL_W+1:0]  cls_s;
  logic signed [CEIL_W+1:0]  cls_c;
  logic signed [CEIL_W+1:0]  hand_lo;
  logic signed [CEIL_W+1:0]  touch_lo;
  logic                      cls_hand;
  logic                      cls_touch;

  logic                      ref_we;
  logic                      row_we;
  logic                      ceil_we;
  logic [ROW_W-1:0]          row_wd;
  logic signed [CEIL_W-1:0]  res_ceil;
  logic                      res_hand;
  logic                      res_touch;

  // Memory ports: one write from the committed item, one read at capture.
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem_r[pix_r] <= sample_r;
    end
    if (cmd.capture) begin
      ref_rd_r <= ref_mem_r[in_pixel_index];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem_r[pix_r] <= row_wd;
    end
    if (cmd.capture) begin
      row_rd_r <= row_mem_r[in_pixel_index];
    end
  end

  always_ff @(posedge clk) begin
    if (ceil_we) begin
      ceil_mem_r[pix_r] <= ceil_calc;
    end
    if (cmd.capture) begin
      ceil_rd_r <= ceil_mem_r[in_pixel_index];
    end
  end

  // Bin scan for finalize, one bin per cycle from the latched row.
  assign scan_cnt = row_rd_r[{scan_d_r, 3'b000} +: CNT_W];
  assign scan_hit = (scan_cnt >= cfg.count_threshold);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= mode_t'(in_mode);
      pix_r    <= in_pixel_index;
      sample_r <= in_depth_sample;
      scan_d_r <= '0;
      sel_d_r  <= '0;
      best_r   <= '0;
      have_r   <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_d_r <= scan_d_r + BIN_W'(1);
      if (scan_hit) begin
        sel_d_r <= scan_d_r;
        have_r  <= 1'b1;
      end else if (scan_cnt > best_r) begin
        best_r  <= scan_cnt;
        sel_d_r <= scan_d_r;
        have_r  <= 1'b1;
      end
    end
  end

  always_comb begin
    sample_nz = (sample_r != '0);
    ref_zero  = (ref_rd_r == '0);

    // accumulate: deviation from reference, clamped to the bin range
    bin_diff = CEIL_W'(sample_r) - CEIL_W'(ref_rd_r) + CEIL_W'(cfg.mid_bin);
    if (bin_diff < 0) begin
      bin_sel = '0;
    end else if (bin_diff > BIN_MAX_S) begin
      bin_sel = BIN_LAST;
    end else begin
      bin_sel = bin_diff[BIN_W-1:0];
    end
    bin_cnt = row_rd_r[{bin_sel, 3'b000} +: CNT_W];
    bin_inc = (bin_cnt == CNT_SAT) ? bin_cnt : bin_cnt + CNT_W'(1);

    // finalize: empty histogram leaves the ceiling at zero
    if (have_r) begin
      ceil_calc = CEIL_W'(ref_rd_r) + CEIL_W'(sel_d_r) - CEIL_W'(cfg.mid_bin)
                  - CEIL_W'(cfg.touch_thickness);
    end else begin
      ceil_calc = '0;
    end

    // classify, two guard bits so the floors cannot wrap
    cls_s     = $signed({4'b0000, sample_r});
    cls_c     = {{2{ceil_rd_r[CEIL_W-1]}}, ceil_rd_r};
    hand_lo   = cls_c - $signed((CEIL_W+2)'(cfg.hand_thickness));
    touch_lo  = cls_c - $signed((CEIL_W+2)'(cfg.finger_thickness));
    cls_hand  = (cls_s < cls_c) && (cls_s > hand_lo);
    cls_touch = (cls_c > 0) && (cls_s < cls_c) && (cls_s > touch_lo);

    ref_we    = 1'b0;
    row_we    = 1'b0;
    ceil_we   = 1'b0;
    row_wd    = row_rd_r;
    res_ceil  = '0;
    res_hand  = 1'b0;
    res_touch = 1'b0;
    unique case (mode_r)
      MODE_INIT: begin
        ref_we = 1'b1;
        row_we = 1'b1;
        row_wd = '0;
        if (sample_nz) begin
          row_wd[{mid_slot(cfg.mid_bin), 3'b000} +: CNT_W] = CNT_W'(1);
        end
      end
      MODE_ACCUM: begin
        if (sample_nz) begin
          row_we = 1'b1;
          if (ref_zero) begin
            ref_we = 1'b1;
            row_wd[{mid_slot(cfg.mid_bin), 3'b000} +: CNT_W] = CNT_W'(1);
          end else begin
            row_wd[{bin_sel, 3'b000} +: CNT_W] = bin_inc;
          end
        end
      end
      MODE_FINAL: begin
        ceil_we  = 1'b1;
        res_ceil = ceil_calc;
      end
      MODE_CLASSIFY: begin
        res_ceil  = ceil_rd_r;
        res_hand  = cls_hand;
        res_touch = cls_touch;
      end
      default: begin
        res_ceil = '0;
      end
    endcase
    ref_we  = ref_we && cmd.commit;
    row_we  = row_we && cmd.commit;
    ceil_we = ceil_we && cmd.commit;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ceil_r  <= res_ceil;
      out_hand_r  <= res_hand;
      out_touch_r <= res_touch;
    end
  end

  assign st.in_finalize = (mode_t'(in_mode) == MODE_FINAL);
  assign st.scan_done   = scan_hit || (scan_d_r == BIN_LAST);
  assign st.out_free    = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_ceiling_depth = out_ceil_r;
  assign out_hand_bit      = out_hand_r;
  assign out_touch_bit     = out_touch_r;

  `DBH_ASSERT_NEXT(a_scan_clear, cmd.capture, (scan_d_r == '0 && !have_r && best_r == '0), "scan state not cleared on capture")
  `DBH_ASSERT_NEXT(a_empty_ceil, (cmd.commit && mode_r == MODE_FINAL && !have_r), (out_ceiling_depth == '0), "empty histogram gave a nonzero ceiling")
  `DBH_ASSERT(a_touch_ceil, (out_valid && out_touch_bit) |-> (out_ceiling_depth > 0), "touch reported under a non-positive ceiling")

endmodule

FILE: src/depth_background_histogram_model_top.sv
`timescale 1ns / 1ps

// Per-pixel background depth model. Init, accumulate and classify items
// first accept the item and read the pixel's reference, bin row and ceiling
// memories, then update the memories and load the result register.
// Finalize walks the bin row between these, one bin per cycle, and the walk
// stops at the first bin that reaches count_threshold or at the last bin.
// A new item is accepted only once the previous one has written back, but a
// finished result may sit in the output register while the next item is
// taken; an unclaimed result holds the following update.
// The memories are not cleared after reset: initialize a pixel before
// accumulating or finalizing it, and finalize it before classifying.
module depth_background_histogram_model_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_mode,
  input  logic [dbh_pkg::PIX_W-1:0]           in_pixel_index,
  input  logic [dbh_pkg::DEPTH_W-1:0]         in_depth_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dbh_pkg::CEIL_W-1:0]   out_ceiling_depth,
  output logic                                out_hand_bit,
  output logic                                out_touch_bit,
  input  logic                                cfg_wr_en,
  input  logic [dbh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dbh_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import dbh_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;

  dbh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dbh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dbh_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg),
    .in_mode           (in_mode),
    .in_pixel_index    (in_pixel_index),
    .in_depth_sample   (in_depth_sample),
    .out_stall         (out_stall),
    .st                (st),
    .out_valid         (out_valid),
    .out_ceiling_depth (out_ceiling_depth),
    .out_hand_bit      (out_hand_bit),
    .out_touch_bit     (out_touch_bit)
  );

endmodule
